@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the RTL; included by inversion_counter_fenwick.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk_i, suspended while rst_ni is low.
`define ICF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every rising edge of clk_i, reset included.
`define ICF_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

@@ hw/rtl/icf_pkg.sv @@
`default_nettype none

package icf_pkg;

  localparam int unsigned MAX_SIZE_DEF = 1024;

  localparam int unsigned SIZE_W    = 11;
  localparam int unsigned VALUE_W   = 10;
  localparam int unsigned GREATER_W = 10;
  localparam int unsigned TOTAL_W   = 19;
  localparam int unsigned CNT_W     = 11;

  localparam logic [SIZE_W-1:0]    SIZE_RST    = 11'd1024;
  localparam logic [GREATER_W-1:0] GREATER_MAX = '1;
  localparam logic [TOTAL_W-1:0]   TOTAL_MAX   = '1;

endpackage

`default_nettype wire

@@ hw/rtl/icf_in_if.sv @@
`default_nettype none

interface icf_in_if;
  logic                         valid;
  logic                         ready;
  logic [icf_pkg::VALUE_W-1:0]  value;
  logic                         last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/icf_out_if.sv @@
`default_nettype none

interface icf_out_if;
  logic                          valid;
  logic                          ready;
  logic [icf_pkg::GREATER_W-1:0] greater_seen;
  logic [icf_pkg::TOTAL_W-1:0]   total_inversions;
  logic                          total_odd;
  logic                          bad_value;
  logic                          is_last;

  modport source (output valid, output greater_seen, output total_inversions,
                  output total_odd, output bad_value, output is_last, input ready);
  modport sink   (input valid, input greater_seen, input total_inversions,
                  input total_odd, input bad_value, input is_last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/icf_ram.sv @@
`default_nettype none

module icf_ram #(
  parameter int unsigned WIDTH = icf_pkg::CNT_W,
  parameter int unsigned DEPTH = icf_pkg::MAX_SIZE_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hw/rtl/inversion_counter_fenwick.sv @@
// A legal value is handled in order by a query walk down from n, a query walk down from the
// value, an update walk up from the value and a finish step; an out-of-range or zero value
// skips the walks and goes straight from acceptance to the finish step.
// Throughput: one item at a time, set by the single read and single write port of the tree
// RAM that both query walks and the update walk share. Reset is asynchronous, active low;
// after reset and after each last transaction a clearing pass zeroes the tree.
`default_nettype none

module inversion_counter_fenwick #(
  parameter int unsigned MAX_SIZE = icf_pkg::MAX_SIZE_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [icf_pkg::SIZE_W-1:0] cfg_wdata_i,
  icf_in_if.sink                          in_i,
  icf_out_if.source                       out_o
);

  `include "assert_macros.svh"

  localparam int unsigned AW = $clog2(MAX_SIZE);
  localparam int unsigned PW = $clog2(MAX_SIZE + 1);
  localparam int unsigned UW = PW + 1;
  localparam int unsigned CW = (UW > icf_pkg::SIZE_W) ? UW : icf_pkg::SIZE_W;
  localparam int unsigned CNT_W = icf_pkg::CNT_W;
  localparam int unsigned TOTAL_W = icf_pkg::TOTAL_W;
  localparam int unsigned GREATER_W = icf_pkg::GREATER_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_QN,
    S_QV,
    S_UPD,
    S_FIN
  } state_e;

  state_e                   state_q;
  logic [icf_pkg::SIZE_W-1:0] size_q;
  logic [UW-1:0]            u_q;
  logic [UW-1:0]            v_q;
  logic                     pend_q;
  logic [CNT_W-1:0]         acc_q;
  logic [AW-1:0]            wr_addr_q;
  logic [AW-1:0]            clr_q;
  logic                     bad_q;
  logic                     last_q;
  logic [TOTAL_W-1:0]       total_q;
  logic                     out_valid_q;
  logic [GREATER_W-1:0]     out_greater_q;
  logic [TOTAL_W-1:0]       out_total_q;
  logic                     out_bad_q;
  logic                     out_last_q;

  logic [CW-1:0]            size_ext;
  logic [CW-1:0]            n_clip;
  logic [UW-1:0]            n;
  logic [CW-1:0]            v_ext;
  logic                     in_bad;
  logic [UW-1:0]            lowbit;
  logic [UW-1:0]            u_dec;
  logic [UW-1:0]            u_inc;
  logic [UW-1:0]            u_minus1;
  logic [AW-1:0]            rd_addr;
  logic                     upd_go;
  logic [GREATER_W-1:0]     greater_c;
  logic [TOTAL_W:0]         total_sum;
  logic [TOTAL_W-1:0]       total_upd;
  logic                     fin_load;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [CNT_W-1:0]         ram_wdata;
  logic [CNT_W-1:0]         ram_rdata;

  assign size_ext = CW'(size_q);
  assign n_clip   = (size_ext > CW'(MAX_SIZE)) ? CW'(MAX_SIZE) : size_ext;
  assign n        = n_clip[UW-1:0];
  assign v_ext    = CW'(in_i.value);
  assign in_bad   = (in_i.value == '0) || (v_ext > n_clip);

  // Lowest set bit of the walk index: stripped on a query, added on an update.
  assign lowbit   = u_q & (~u_q + UW'(1));
  assign u_dec    = u_q - lowbit;
  assign u_inc    = u_q + lowbit;
  assign u_minus1 = u_q - UW'(1);
  assign rd_addr  = u_minus1[AW-1:0];
  assign upd_go   = (u_q != '0) && (u_q <= n);

  assign greater_c = bad_q ? '0 :
                     (acc_q > CNT_W'(icf_pkg::GREATER_MAX)) ? icf_pkg::GREATER_MAX :
                     acc_q[GREATER_W-1:0];
  assign total_sum = {1'b0, total_q} + (TOTAL_W + 1)'(greater_c);
  assign total_upd = total_sum[TOTAL_W] ? icf_pkg::TOTAL_MAX : total_sum[TOTAL_W-1:0];
  assign fin_load  = (state_q == S_FIN) && (!out_valid_q || out_o.ready);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_addr_q;
    ram_wdata = ram_rdata + CNT_W'(1);
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      S_UPD: begin
        ram_we = pend_q;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  icf_ram #(
    .WIDTH (CNT_W),
    .DEPTH (MAX_SIZE)
  ) u_tree (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      size_q      <= icf_pkg::SIZE_RST;
      clr_q       <= '0;
      u_q         <= '0;
      pend_q      <= 1'b0;
      acc_q       <= '0;
      bad_q       <= 1'b0;
      last_q      <= 1'b0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
      if (out_valid_q && out_o.ready && !fin_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(MAX_SIZE - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_i.valid) begin
            v_q    <= in_bad ? '0 : v_ext[UW-1:0];
            bad_q  <= in_bad;
            last_q <= in_i.last;
            acc_q  <= '0;
            pend_q <= 1'b0;
            u_q    <= n;
            state_q <= in_bad ? S_FIN : S_QN;
          end
        end
        S_QN: begin
          // Reads are issued back to back; each word is summed in the cycle after its address.
          pend_q <= (u_q != '0);
          if (pend_q) begin
            acc_q <= acc_q + ram_rdata;
          end
          if (u_q == '0) begin
            u_q     <= v_q;
            state_q <= S_QV;
          end else begin
            u_q     <= u_dec;
          end
        end
        S_QV: begin
          pend_q <= (u_q != '0);
          if (pend_q) begin
            acc_q <= acc_q - ram_rdata;
          end
          if (u_q == '0) begin
            u_q     <= v_q;
            state_q <= S_UPD;
          end else begin
            u_q     <= u_dec;
          end
        end
        S_UPD: begin
          // The incremented word is written while the next node is read; the
          // walk only climbs, so the two addresses never coincide.
          pend_q    <= upd_go;
          wr_addr_q <= rd_addr;
          u_q       <= u_inc;
          if (!upd_go) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_load) begin
            out_valid_q   <= 1'b1;
            out_greater_q <= greater_c;
            out_total_q   <= total_upd;
            out_bad_q     <= bad_q;
            out_last_q    <= last_q;
            total_q       <= last_q ? '0 : total_upd;
            clr_q         <= '0;
            state_q       <= last_q ? S_CLEAR : S_IDLE;
          end
        end
        default: begin
          state_q <= S_CLEAR;
        end
      endcase
    end
  end

  assign in_i.ready             = (state_q == S_IDLE);
  assign out_o.valid            = out_valid_q;
  assign out_o.greater_seen     = out_greater_q;
  assign out_o.total_inversions = out_total_q;
  assign out_o.total_odd        = out_total_q[0];
  assign out_o.bad_value        = out_bad_q;
  assign out_o.is_last          = out_last_q;

  `ICF_ASSERT(a_no_write_in_query, ((state_q == S_QN) || (state_q == S_QV)) |-> !ram_we, "tree written during a query walk")
  `ICF_ASSERT(a_busy_after_accept, (in_i.valid && in_i.ready) |=> !in_i.ready, "input taken while an item is in progress")
  `ICF_ASSERT(a_result_from_fin, $rose(out_valid_q) |-> $past(state_q == S_FIN), "result raised outside the finish step")
  `ICF_ASSERT(a_last_clears, (fin_load && last_q) |=> ((total_q == '0) && (state_q == S_CLEAR)), "total or tree not cleared after the last transaction")
  `ICF_ASSERT_NR(a_clear_writes_zero, (state_q == S_CLEAR) |-> (ram_we && (ram_wdata == '0)), "clearing pass missed a tree word")

endmodule

`default_nettype wire
